/* sv/usd_pkg.sv */
// ----------------------------------------------------------------------------
// usd_pkg: shared types and codes of the UTF-8 stream decoder
// Byte classes passed from the front end to the decode back end, and the
// status codes of a result item.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 31;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LeftW  = 3;
  localparam int unsigned BitsW  = 7;
  localparam int unsigned ContW  = 6;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ASCII   = 2'd0;
  localparam kind_t KIND_CONT    = 2'd1;
  localparam kind_t KIND_LEAD    = 2'd2;
  localparam kind_t KIND_INVALID = 2'd3;

  typedef logic [StatW-1:0] status_t;
  localparam status_t ST_READY      = 2'd0;
  localparam status_t ST_PENDING    = 2'd1;
  localparam status_t ST_INCOMPLETE = 2'd2;
  localparam status_t ST_BAD_START  = 2'd3;

  // One classified byte. For a lead byte, lead_len holds the number of
  // continuation bytes that follow and bits holds the masked payload.
  typedef struct packed {
    kind_t             kind;
    logic [LeftW-1:0]  lead_len;
    logic [BitsW-1:0]  bits;
  } item_t;

  // Handshake status of the item queue as seen by its two neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/usd_front.sv */
// ----------------------------------------------------------------------------
// usd_front: input stage and byte classifier
// Accepts one byte per cycle while in_full is low, classifies it and holds it
// in a register until the item queue takes it.
// ----------------------------------------------------------------------------
module usd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [usd_pkg::ByteW-1:0]    in_byte_in,
  input  usd_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output usd_pkg::item_t               q_item
);

  logic           vld_r;
  logic           vld_nxt;
  usd_pkg::item_t item_r;
  usd_pkg::item_t item_nxt;
  logic           accept;

  always_comb begin
    item_nxt = '0;
    if (in_byte_in[7] == 1'b0) begin
      item_nxt.kind = usd_pkg::KIND_ASCII;
      item_nxt.bits = in_byte_in[6:0];
    end else if (in_byte_in[6] == 1'b0) begin
      item_nxt.kind = usd_pkg::KIND_CONT;
      item_nxt.bits = {1'b0, in_byte_in[5:0]};
    end else if (in_byte_in[5] == 1'b0) begin
      item_nxt.kind     = usd_pkg::KIND_LEAD;
      item_nxt.lead_len = 3'd1;
      item_nxt.bits     = {2'b00, in_byte_in[4:0]};
    end else if (in_byte_in[4] == 1'b0) begin
      item_nxt.kind     = usd_pkg::KIND_LEAD;
      item_nxt.lead_len = 3'd2;
      item_nxt.bits     = {3'b000, in_byte_in[3:0]};
    end else if (in_byte_in[3] == 1'b0) begin
      item_nxt.kind     = usd_pkg::KIND_LEAD;
      item_nxt.lead_len = 3'd3;
      item_nxt.bits     = {4'b0000, in_byte_in[2:0]};
    end else if (in_byte_in[2] == 1'b0) begin
      item_nxt.kind     = usd_pkg::KIND_LEAD;
      item_nxt.lead_len = 3'd4;
      item_nxt.bits     = {5'b00000, in_byte_in[1:0]};
    end else if (in_byte_in[1] == 1'b0) begin
      item_nxt.kind     = usd_pkg::KIND_LEAD;
      item_nxt.lead_len = 3'd5;
      item_nxt.bits     = {6'b000000, in_byte_in[0]};
    end else begin
      item_nxt.kind = usd_pkg::KIND_INVALID;
    end
  end

  // The held item moves on whenever the queue has room, so a new byte can
  // be taken in the same cycle.
  assign q_push  = vld_r && !q_stat.full;
  assign q_item  = item_r;
  assign in_full = vld_r && q_stat.full;
  assign accept  = in_push && !in_full;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* sv/usd_queue.sv */
// ----------------------------------------------------------------------------
// usd_queue: two-entry item queue
// Decouples the classifier from the decode back end.
// ----------------------------------------------------------------------------
module usd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  usd_pkg::item_t   push_item,
  input  logic             pop,
  output usd_pkg::item_t   head_item,
  output usd_pkg::q_stat_t stat
);

  usd_pkg::item_t ent_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* sv/usd_back.sv */
// ----------------------------------------------------------------------------
// usd_back: sequence decoder and result queue
// Keeps the count of continuation bytes still expected and the partial code
// point, and writes one result item per classified byte into a two-entry
// output queue.
// ----------------------------------------------------------------------------
module usd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  usd_pkg::item_t               q_item,
  input  usd_pkg::q_stat_t             q_stat,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [usd_pkg::StatW-1:0]    out_status,
  output logic [usd_pkg::CodeW-1:0]    out_code_point
);

  logic [usd_pkg::LeftW-1:0] left_r;
  logic [usd_pkg::LeftW-1:0] left_nxt;
  logic [usd_pkg::CodeW-1:0] pv_r;
  logic [usd_pkg::CodeW-1:0] pv_nxt;
  usd_pkg::status_t          res_status;
  logic [usd_pkg::CodeW-1:0] res_code;

  usd_pkg::status_t          ost_r   [2];
  logic [usd_pkg::CodeW-1:0] ocode_r [2];
  logic                      owr_r;
  logic                      ord_r;
  logic [1:0]                ocnt_r;
  logic [1:0]                ocnt_nxt;
  logic                      take_out;

  assign out_empty      = (ocnt_r == 2'd0);
  assign take_out       = out_pop && !out_empty;
  assign out_status     = ost_r[ord_r];
  assign out_code_point = ocode_r[ord_r];

  // A byte leaves the item queue whenever its result has a slot, counting
  // the slot freed by a pop in the same cycle.
  assign q_pop = !q_stat.empty && ((ocnt_r != 2'd2) || take_out);

  always_comb begin
    left_nxt   = left_r;
    pv_nxt     = pv_r;
    res_status = usd_pkg::ST_PENDING;
    res_code   = '0;
    if (left_r != '0) begin
      if (q_item.kind == usd_pkg::KIND_CONT) begin
        left_nxt = left_r - 3'd1;
        pv_nxt   = {pv_r[usd_pkg::CodeW-usd_pkg::ContW-1:0],
                    q_item.bits[usd_pkg::ContW-1:0]};
        if (left_nxt == '0) begin
          res_status = usd_pkg::ST_READY;
          res_code   = pv_nxt;
        end
      end else begin
        // The interrupting byte is dropped, not taken as a new lead.
        left_nxt   = '0;
        res_status = usd_pkg::ST_INCOMPLETE;
      end
    end else begin
      unique case (q_item.kind)
        usd_pkg::KIND_ASCII: begin
          res_status = usd_pkg::ST_READY;
          res_code   = {{(usd_pkg::CodeW-usd_pkg::BitsW){1'b0}}, q_item.bits};
        end
        usd_pkg::KIND_LEAD: begin
          left_nxt = q_item.lead_len;
          pv_nxt   = {{(usd_pkg::CodeW-usd_pkg::BitsW){1'b0}}, q_item.bits};
        end
        default: begin
          res_status = usd_pkg::ST_BAD_START;
        end
      endcase
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (q_pop && !take_out) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (take_out && !q_pop) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      pv_r   <= '0;
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (q_pop) begin
        left_r <= left_nxt;
        pv_r   <= pv_nxt;
        owr_r  <= !owr_r;
      end
      if (take_out) begin
        ord_r <= !ord_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ost_r[owr_r]   <= res_status;
      ocode_r[owr_r] <= res_code;
    end
  end

endmodule

/* sv/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder: original UTF-8 decoder, one byte per item
// Decodes sequences of up to six bytes into 31-bit code points.
// ----------------------------------------------------------------------------
// Usage:
//   The input side is a queue: drive in_byte_in and raise in_push; the byte
//   is taken at a clock edge where in_full is low. Every byte gives exactly
//   one result item on the output side, which is also a queue: while
//   out_empty is low, out_status and out_code_point show the oldest result,
//   and raising out_pop takes it at the clock edge.
//   Status 0 carries a code point, 1 means the byte was taken and a sequence
//   is pending, 2 reports an interrupted sequence (the interrupting byte is
//   dropped), 3 a bad start byte. out_code_point is zero unless status is 0.
//   Each result passes through the input register, the item queue and the
//   result queue on its way to the output ports.
//   Throughput: one byte per cycle while in_full is low; the back end updates
//   the continuation count and partial value once for each byte.
//   When the receiver stalls, the two-entry result queue, the two-entry item
//   queue and the input register fill in turn, then in_full rises.
//   Reset (synchronous, rst_n low) empties all queues and clears the
//   sequence state; in_full is low and out_empty high right after it.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [usd_pkg::ByteW-1:0]    in_byte_in,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [usd_pkg::StatW-1:0]    out_status,
  output logic [usd_pkg::CodeW-1:0]    out_code_point
);

  usd_pkg::q_stat_t q_stat;
  usd_pkg::item_t   push_item;
  usd_pkg::item_t   head_item;
  logic             q_push;
  logic             q_pop;

  usd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_byte_in (in_byte_in),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  usd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  usd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (head_item),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_code_point (out_code_point)
  );

endmodule

/* sv/usd_checker.sv */
// ----------------------------------------------------------------------------
// usd_checker: port-level assertions for the UTF-8 stream decoder
// Watches the top level's ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module usd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_push,
  input logic                         in_full,
  input logic [usd_pkg::ByteW-1:0]    in_byte_in,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [usd_pkg::StatW-1:0]    out_status,
  input logic [usd_pkg::CodeW-1:0]    out_code_point
);

  // A waiting result that is not taken stays on the ports.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
                                  && $stable(out_code_point)))
    else $error("usd: waiting result changed before it was taken");

  // Only a ready status carries a code point.
  a_zero_code : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != usd_pkg::ST_READY)) |-> (out_code_point == '0))
    else $error("usd: nonzero code point with a non-ready status");

  // Reset leaves both sides empty and ready.
  a_reset : assert property (@(posedge clk)
    $rose(rst_n) |-> (out_empty && !in_full))
    else $error("usd: queues not empty after reset");

  // An accepted ASCII byte into an idle, empty block comes back as itself.
  // The result reaches the ports through the input register, the item queue and
  // the result queue.
  a_ascii : assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && !in_byte_in[7] && out_empty
     && $past(out_empty) && $past(!in_push) && $past(out_empty, 2)
     && $past(!in_push, 2) && $past(out_empty, 3) && $past(!in_push, 3)
     && $past(rst_n, 3) && $past(!rst_n, 4))
    |-> ##3 (!out_empty && (out_status == usd_pkg::ST_READY)
             && (out_code_point == {{(usd_pkg::CodeW-7){1'b0}},
                                    $past(in_byte_in[6:0], 3)})))
    else $error("usd: ASCII byte after reset not returned as is");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .in_byte_in     (in_byte_in),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_status     (out_status),
  .out_code_point (out_code_point)
);

/* bench/tb_utf8_stream_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder: self-checking bench for the UTF-8 stream decoder
// A clocked driver feeds bytes from a queue into the input channel. Every
// accepted byte is decoded by a behavioral predictor, and a clocked monitor
// checks each popped result against the oldest prediction. The stimulus is a
// short directed run followed by random well-formed, broken and noise bytes
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

  typedef struct packed {
    usd_pkg::status_t                status;
    logic [usd_pkg::CodeW-1:0]       code;
  } decoded_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  logic [usd_pkg::ByteW-1:0]       in_byte_in = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic [usd_pkg::StatW-1:0]       out_status;
  logic [usd_pkg::CodeW-1:0]       out_code_point;

  logic [usd_pkg::ByteW-1:0]       stream_bytes[$];
  decoded_t                        expected_chars[$];
  int unsigned                     send_idle_pct = 0;
  int unsigned                     recv_stall_pct = 0;
  int unsigned                     errors = 0;

  // Predictor state: continuation bytes still due and the payload so far.
  logic [usd_pkg::LeftW-1:0]       seq_left = '0;
  logic [usd_pkg::CodeW-1:0]       seq_value = '0;

  utf8_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte_in     (in_byte_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_code_point (out_code_point)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic decoded_t decode_byte(input logic [usd_pkg::ByteW-1:0] b);
    decoded_t r;
    r.status = usd_pkg::ST_PENDING;
    r.code   = '0;
    if (seq_left != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_left  = seq_left - 3'd1;
        seq_value = {seq_value[usd_pkg::CodeW-7:0], b[5:0]};
        if (seq_left == 0) begin
          r.status = usd_pkg::ST_READY;
          r.code   = seq_value;
        end
      end else begin
        // The interrupting byte is dropped, not taken as a new lead.
        seq_left = '0;
        r.status = usd_pkg::ST_INCOMPLETE;
      end
    end else begin
      casez (b)
        8'b0???????: begin
          r.status = usd_pkg::ST_READY;
          r.code   = {{(usd_pkg::CodeW-8){1'b0}}, b};
        end
        8'b110?????: begin
          seq_left  = 3'd1;
          seq_value = {{(usd_pkg::CodeW-5){1'b0}}, b[4:0]};
        end
        8'b1110????: begin
          seq_left  = 3'd2;
          seq_value = {{(usd_pkg::CodeW-4){1'b0}}, b[3:0]};
        end
        8'b11110???: begin
          seq_left  = 3'd3;
          seq_value = {{(usd_pkg::CodeW-3){1'b0}}, b[2:0]};
        end
        8'b111110??: begin
          seq_left  = 3'd4;
          seq_value = {{(usd_pkg::CodeW-2){1'b0}}, b[1:0]};
        end
        8'b1111110?: begin
          seq_left  = 3'd5;
          seq_value = {{(usd_pkg::CodeW-1){1'b0}}, b[0]};
        end
        default: r.status = usd_pkg::ST_BAD_START;
      endcase
    end
    return r;
  endfunction

  // Mostly well-formed sequences of random length and payload, mixed with broken
  // sequences and single random bytes.
  task automatic gen_random_bytes(input int unsigned count);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [usd_pkg::ByteW-1:0] b;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(99);
      len  = $urandom_range(5);
      b = 8'($urandom_range(255));
      if (kind < 85 && len != 0) begin
        stream_bytes.push_back((8'hFF << (7 - len)) | (b & (8'h7F >> (len + 1))));
        added++;
        cut = (kind < 70) ? len : $urandom_range(len - 1);
        for (int i = 0; i < cut; i++) begin
          stream_bytes.push_back({2'b10, 6'($urandom_range(63))});
          added++;
        end
        if (cut < len) begin
          b = 8'($urandom_range(255));
          if (b[7:6] == 2'b10) begin
            b[7] = 1'b0;
          end
          stream_bytes.push_back(b);
          added++;
        end
      end else begin
        stream_bytes.push_back(b);
        added++;
      end
    end
  endtask

  always @(posedge clk) begin : drive
    logic go;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expected_chars.push_back(decode_byte(in_byte_in));
        void'(stream_bytes.pop_front());
      end
      go = (stream_bytes.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      in_push <= go;
      if (go) begin
        in_byte_in <= stream_bytes[0];
      end
    end
  end

  always @(posedge clk) begin : watch
    decoded_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: status %0d code_point 0x%0h", out_status, out_code_point);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_code_point !== want.code) begin
            $error("code_point: expected 0x%0h, got 0x%0h", want.code, out_code_point);
            errors++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [usd_pkg::ByteW-1:0] directed[$];
    directed = '{
      8'h00, 8'hFF, 8'h80, 8'hFE, 8'h7F,
      8'hC2, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
      8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
      8'hE2, 8'h41,
      8'hC3, 8'hF0
    };
    foreach (directed[i]) begin
      stream_bytes.push_back(directed[i]);
    end
    for (int phase = 0; phase < 5; phase++) begin
      while (stream_bytes.size() != 0 || expected_chars.size() != 0) begin
        @(posedge clk);
      end
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        3: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase < 4) begin
        gen_random_bytes(280);
      end
    end
    // Let any stray result drain out before the verdict.
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_stream_decoder test passed");
    end else begin
      $display("utf8_stream_decoder test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("utf8_stream_decoder test failed");
    $finish;
  end

endmodule
